[rtl/dptt_pkg.sv]
// dptt_pkg: shared types and constants for the depth-preferred transposition table.
// Used by dptt_slot, dptt_table and depth_preferred_transposition_table.
package dptt_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int KEY_W       = 64;
  localparam int DEPTH_W     = 7;
  localparam int SCORE_W     = 32;
  localparam int BOUND_W     = 2;
  localparam int MOVE_W      = 16;

  // modulo unit for non power-of-two table sizes: bits per cycle
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;

  localparam logic FUNC_PROBE = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

  typedef struct packed {
    logic                      func;
    logic [KEY_W-1:0]          hash_key;
    logic [DEPTH_W-1:0]        search_depth;
    logic signed [SCORE_W-1:0] new_score;
    logic [BOUND_W-1:0]        bound_kind;
    logic [MOVE_W-1:0]         new_move;
    logic signed [SCORE_W-1:0] window_low;
    logic signed [SCORE_W-1:0] window_high;
  } req_word_t;

  typedef struct packed {
    logic                      key_found;
    logic                      score_usable;
    logic signed [SCORE_W-1:0] found_score;
    logic [MOVE_W-1:0]         found_move;
  } rsp_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic [DEPTH_W-1:0]        depth;
    logic signed [SCORE_W-1:0] score;
    logic [BOUND_W-1:0]        bound;
    logic [MOVE_W-1:0]         move;
  } entry_t;

endpackage

[rtl/dptt_slot.sv]
// dptt_slot: maps a request word to its table slot (hash_key modulo ENTRIES).
// Power-of-two sizes take the low key bits; other sizes use an iterative remainder unit.
// Depends on dptt_pkg.
module dptt_slot #(
  parameter int ENTRIES = dptt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  dptt_pkg::req_word_t req,
  output logic                slot_valid,
  input  logic                slot_ready,
  output dptt_pkg::req_word_t slot_word,
  output logic [IDX_W-1:0]    slot
);

  localparam bit POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

  if (POW2) begin : g_pow2
    assign slot_valid = req_valid;
    assign req_ready  = slot_ready;
    assign slot_word  = req;
    assign slot       = req.hash_key[IDX_W-1:0];
  end else begin : g_mod
    localparam int CNT_W = $clog2(dptt_pkg::MOD_STEPS);

    logic                        busy;
    logic                        done;
    logic [CNT_W-1:0]            cnt;
    logic [IDX_W-1:0]            rem;
    logic [IDX_W-1:0]            rem_next;
    logic [dptt_pkg::KEY_W-1:0]  sh;
    dptt_pkg::req_word_t         hold;

    always_comb begin
      logic [IDX_W:0] t;
      logic [IDX_W-1:0] r;
      t = '0;
      r = rem;
      for (int i = 0; i < dptt_pkg::MOD_BITS; i++) begin
        t = {r, sh[dptt_pkg::KEY_W-1-i]};
        if (t >= (IDX_W+1)'(ENTRIES)) begin
          t = t - (IDX_W+1)'(ENTRIES);
        end
        r = t[IDX_W-1:0];
      end
      rem_next = r;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        done <= 1'b0;
        cnt  <= '0;
      end else if (!busy) begin
        if (req_valid) begin
          busy <= 1'b1;
          done <= 1'b0;
          cnt  <= '0;
        end
      end else if (!done) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(dptt_pkg::MOD_STEPS - 1)) begin
          done <= 1'b1;
        end
      end else if (slot_ready) begin
        busy <= 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!busy) begin
        rem  <= '0;
        sh   <= req.hash_key;
        hold <= req;
      end else if (!done) begin
        rem <= rem_next;
        sh  <= sh << dptt_pkg::MOD_BITS;
      end
    end

    assign req_ready  = !busy;
    assign slot_valid = busy && done;
    assign slot_word  = hold;
    assign slot       = rem;
  end

endmodule

[rtl/dptt_table.sv]
// dptt_table: entry memory with clearing pass, read stage, replace/probe logic.
// Read-modify-write with write-to-read forwarding on back-to-back items.
// Depends on dptt_pkg.
module dptt_table #(
  parameter int ENTRIES = dptt_pkg::ENTRIES_DEF,
  parameter int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  dptt_pkg::req_word_t item,
  input  logic [IDX_W-1:0]    item_slot,
  output logic                res_valid,
  input  logic                res_ready,
  output dptt_pkg::rsp_word_t res
);

  dptt_pkg::entry_t mem [ENTRIES];

  logic                clr_busy;
  logic [IDX_W-1:0]    clr_addr;

  logic                st_valid;
  dptt_pkg::req_word_t st_item;
  logic [IDX_W-1:0]    st_slot;
  dptt_pkg::entry_t    rd_q;
  logic                fwd_hit;
  dptt_pkg::entry_t    fwd_entry;

  dptt_pkg::entry_t    cur;
  dptt_pkg::entry_t    new_entry;
  logic                is_store;
  logic                replace;
  logic                st_go;
  logic                accept;
  logic                we;
  logic [IDX_W-1:0]    wa;
  dptt_pkg::entry_t    wd;
  logic                found;
  logic                usable;

  assign cur      = fwd_hit ? fwd_entry : rd_q;
  assign is_store = st_item.func == dptt_pkg::FUNC_STORE;
  assign replace  = (cur.key != st_item.hash_key) || (st_item.search_depth >= cur.depth) ||
                    (st_item.bound_kind == dptt_pkg::BOUND_EXACT);

  assign new_entry.key   = st_item.hash_key;
  assign new_entry.depth = st_item.search_depth;
  assign new_entry.score = st_item.new_score;
  assign new_entry.bound = st_item.bound_kind;
  assign new_entry.move  = st_item.new_move;

  assign st_go      = st_valid && (is_store || res_ready);
  assign item_ready = !clr_busy && (!st_valid || st_go);
  assign accept     = item_valid && item_ready;

  assign we = clr_busy || (st_valid && is_store && replace);
  assign wa = clr_busy ? clr_addr : st_slot;
  assign wd = clr_busy ? '0 : new_entry;

  assign found  = cur.key == st_item.hash_key;
  assign usable = found && (cur.depth >= st_item.search_depth) &&
                  ((cur.bound == dptt_pkg::BOUND_EXACT) ||
                   ((cur.bound == dptt_pkg::BOUND_LOWER) && (cur.score >= st_item.window_high)) ||
                   ((cur.bound == dptt_pkg::BOUND_UPPER) && (cur.score <= st_item.window_low)));

  assign res_valid        = st_valid && !is_store;
  assign res.key_found    = found;
  assign res.score_usable = usable;
  assign res.found_score  = usable ? cur.score : '0;
  assign res.found_move   = found ? cur.move : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(ENTRIES - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (st_go) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (accept) begin
      rd_q      <= mem[item_slot];
      fwd_hit   <= we && (wa == item_slot);
      fwd_entry <= wd;
      st_item   <= item;
      st_slot   <= item_slot;
    end
  end

endmodule

[rtl/depth_preferred_transposition_table.sv]
// Top level: depth-preferred transposition table with registered response word.
// Depends on dptt_pkg, dptt_slot and dptt_table.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries probe or store words.
//   rsp channel (rsp_valid/rsp_ready/rsp) carries one word per probe;
//   stores give no response.
//   Flow: with a power-of-two ENTRIES a probe's response passes the table's
//   read stage and then the output register, and one word is taken every
//   cycle unless a probe waits for the output register; the entry memory
//   does one read and one write per cycle, with forwarding between
//   back-to-back words on the same slot. Other sizes add the remainder unit,
//   which reduces the 64-bit key (8 key bits per cycle) and then hands the
//   word over; it takes no new word until the table has taken the last one.
//   Reset: a clearing pass writes every entry (4096 by default) to zero, one
//   per cycle; with a power-of-two ENTRIES req_ready stays low until it is
//   done, other sizes take one word and hold it.
//   Stall: a held response sits in the output register; the next store may
//   still pass, and a following probe waits until the register frees.
module depth_preferred_transposition_table #(
  parameter int ENTRIES = dptt_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  dptt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output dptt_pkg::rsp_word_t rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic                slot_valid;
  logic                slot_ready;
  dptt_pkg::req_word_t slot_word;
  logic [IDX_W-1:0]    slot;
  logic                res_valid;
  logic                res_ready;
  dptt_pkg::rsp_word_t res;

  dptt_slot #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_slot (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .slot_valid(slot_valid),
    .slot_ready(slot_ready),
    .slot_word (slot_word),
    .slot      (slot)
  );

  dptt_table #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .item_valid(slot_valid),
    .item_ready(slot_ready),
    .item      (slot_word),
    .item_slot (slot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

[verif/depth_preferred_transposition_table_test.sv]
// Self-checking test for depth_preferred_transposition_table: probe and store words with
// random handshake gaps, checked against a behavioral copy of the table.
// Depends on dptt_pkg and the RTL of the block.
module depth_preferred_transposition_table_test;
  import dptt_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;
  localparam int STALL_LIMIT = 4 * (SLOTS + 1000);
  localparam int RANDOM_WORDS = 500;
  localparam logic [BOUND_W-1:0] BOUND_ODD = 2'd3;
  localparam int REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_word_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_word_t rsp;

  req_word_t req_backlog[$];
  rsp_word_t probe_answers[$];

  logic [KEY_W-1:0] tt_key[SLOTS];
  logic [DEPTH_W-1:0] tt_depth[SLOTS];
  logic signed [SCORE_W-1:0] tt_score[SLOTS];
  logic [BOUND_W-1:0] tt_bound[SLOTS];
  logic [MOVE_W-1:0] tt_move[SLOTS];
  logic [KEY_W-1:0] key_pool[32];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int mismatches = 0;
  int n_probes = 0;
  int n_hits = 0;
  int n_usable = 0;
  int n_stores = 0;
  int n_overwrites = 0;

  depth_preferred_transposition_table u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  // table copy: store updates the slot when the replacement rule allows, probe yields the expected response word
  task automatic tt_access(input req_word_t w);
    int s;
    rsp_word_t ans;
    logic signed [SCORE_W-1:0] sc, alpha, beta;
    s = int'(w.hash_key % 64'(SLOTS));
    if (w.func == FUNC_STORE) begin
      n_stores++;
      if (tt_key[s] != w.hash_key || w.search_depth >= tt_depth[s] ||
          w.bound_kind == BOUND_EXACT) begin
        n_overwrites++;
        tt_key[s] = w.hash_key;
        tt_depth[s] = w.search_depth;
        tt_score[s] = w.new_score;
        tt_bound[s] = w.bound_kind;
        tt_move[s] = w.new_move;
      end
    end else begin
      n_probes++;
      sc = tt_score[s];
      alpha = w.window_low;
      beta = w.window_high;
      ans = '0;
      ans.key_found = (tt_key[s] == w.hash_key);
      if (ans.key_found && tt_depth[s] >= w.search_depth) begin
        case (tt_bound[s])
          BOUND_EXACT: ans.score_usable = 1'b1;
          BOUND_LOWER: ans.score_usable = (sc >= beta);
          BOUND_UPPER: ans.score_usable = (sc <= alpha);
          default: ans.score_usable = 1'b0;
        endcase
      end
      if (ans.key_found) begin
        ans.found_move = tt_move[s];
        n_hits++;
      end
      if (ans.score_usable) begin
        ans.found_score = sc;
        n_usable++;
      end
      probe_answers.push_back(ans);
    end
  endtask

  function automatic req_word_t mk(logic f, logic [KEY_W-1:0] k, int d,
                                   logic signed [SCORE_W-1:0] sc, logic [BOUND_W-1:0] b,
                                   logic [MOVE_W-1:0] mv, logic signed [SCORE_W-1:0] lo,
                                   logic signed [SCORE_W-1:0] hi);
    req_word_t w;
    w.func = f;
    w.hash_key = k;
    w.search_depth = DEPTH_W'(d);
    w.new_score = sc;
    w.bound_kind = b;
    w.new_move = mv;
    w.window_low = lo;
    w.window_high = hi;
    return w;
  endfunction

  function automatic req_word_t rand_word();
    req_word_t w;
    w.func = 1'($urandom);
    w.hash_key = {$urandom, $urandom};
    w.search_depth = DEPTH_W'($urandom);
    w.new_score = $urandom;
    w.bound_kind = BOUND_W'($urandom);
    w.new_move = MOVE_W'($urandom);
    w.window_low = $urandom;
    w.window_high = $urandom;
    return w;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    logic signed [SCORE_W-1:0] sc;
    case ($urandom_range(5))
      0: sc = 32'sh8000_0000;
      1: sc = 32'sh7fff_ffff;
      2: sc = '0;
      3: sc = -1;
      4: sc = $signed(32'($urandom_range(16))) - 8;
      default: sc = $urandom;
    endcase
    return sc;
  endfunction

  function automatic logic signed [SCORE_W-1:0] near(logic signed [SCORE_W-1:0] sc);
    return sc + $signed(32'($urandom_range(4))) - 2;
  endfunction

  // mostly store-then-probe runs on a small key pool, plus stray and fully random words
  task automatic queue_random_phase(input int n_words);
    req_word_t w;
    logic [KEY_W-1:0] k;
    logic signed [SCORE_W-1:0] sc;
    int d, dd, kind, reps, added;
    added = 0;
    while (added < n_words) begin
      kind = $urandom_range(9);
      k = key_pool[$urandom_range(31)];
      sc = pick_score();
      d = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(12);
      if (kind < 7) begin
        w = rand_word();
        w.func = FUNC_STORE;
        w.hash_key = k;
        w.search_depth = DEPTH_W'(d);
        w.new_score = sc;
        req_backlog.push_back(w);
        added++;
        reps = 1 + $urandom_range(2);
        for (int r = 0; r < reps; r++) begin
          dd = d + $urandom_range(2) - 1;
          if (dd < 0) dd = 0;
          if (dd > 127) dd = 127;
          w = rand_word();
          w.func = FUNC_PROBE;
          w.hash_key = k;
          w.search_depth = DEPTH_W'(dd);
          w.window_low = near(sc);
          w.window_high = near(sc);
          req_backlog.push_back(w);
          added++;
        end
      end else if (kind < 9) begin
        w = rand_word();
        w.hash_key = k;
        req_backlog.push_back(w);
        added++;
      end else begin
        req_backlog.push_back(rand_word());
        added++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || probe_answers.size() != 0);
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) tt_access(req);
      if (!req_valid || req_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_word_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (probe_answers.size() == 0) begin
          note_mismatch($sformatf("unexpected word found=%0b usable=%0b score=%0d move=%h",
                                  rsp.key_found, rsp.score_usable, rsp.found_score,
                                  rsp.found_move));
        end else begin
          want = probe_answers.pop_front();
          if (rsp.key_found !== want.key_found || rsp.score_usable !== want.score_usable ||
              rsp.found_score !== want.found_score || rsp.found_move !== want.found_move)
            note_mismatch($sformatf(
              "found %0b/%0b usable %0b/%0b score %0d/%0d move %h/%h (expected/actual)",
              want.key_found, rsp.key_found, want.score_usable, rsp.score_usable,
              want.found_score, rsp.found_score, want.found_move, rsp.found_move));
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("depth_preferred_transposition_table test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [KEY_W-1:0] k1, k2, k3, ones, hi;
    for (int i = 0; i < SLOTS; i++) begin
      tt_key[i] = '0;
      tt_depth[i] = '0;
      tt_score[i] = '0;
      tt_bound[i] = BOUND_EXACT;
      tt_move[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      key_pool[16 + i] = hi - hi % 64'(SLOTS) + key_pool[i] % 64'(SLOTS);
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    k1 = 64'h0123_4567_89ab_c005;
    k2 = 64'hfedc_ba98_7654_3005;
    k3 = 64'h5a5a_a5a5_0f0f_f123;
    ones = '1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 19;
    recv_idle_pct = 72;
    // cleared entries, replacement rules, bound edges, odd bound kind, key extremes
    req_backlog.push_back(mk(FUNC_PROBE, '0, 0, 0, BOUND_EXACT, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    req_backlog.push_back(mk(FUNC_PROBE, '0, 127, 0, BOUND_EXACT, 0, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, 64'h8000_0000_0000_0777, 0, 0, BOUND_EXACT, 0, 0, 0));
    req_backlog.push_back(mk(FUNC_STORE, k1, 10, 100, BOUND_LOWER, 16'hffff, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 10, 0, BOUND_EXACT, 0, 0, 100));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 11, 0, BOUND_EXACT, 0, 0, 100));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 0, 0, BOUND_EXACT, 0, 0, 101));
    req_backlog.push_back(mk(FUNC_STORE, k1, 5, 7, BOUND_LOWER, 16'h1111, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 0, 0, BOUND_EXACT, 0, 0, 32'sh8000_0000));
    req_backlog.push_back(mk(FUNC_STORE, k1, 3, -5, BOUND_EXACT, 16'h2222, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 3, 0, BOUND_EXACT, 0, 0, 0));
    req_backlog.push_back(mk(FUNC_STORE, k1, 20, 32'sh8000_0000, BOUND_UPPER, 16'h3333, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 20, 0, BOUND_EXACT, 0, 32'sh8000_0000, 0));
    req_backlog.push_back(mk(FUNC_STORE, k2, 0, 9, BOUND_UPPER, 16'h4444, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k1, 0, 0, BOUND_EXACT, 0, 32'sh7fff_ffff, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k2, 0, 0, BOUND_EXACT, 0, 8, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k2, 0, 0, BOUND_EXACT, 0, 9, 0));
    req_backlog.push_back(mk(FUNC_STORE, k3, 50, 32'sh7fff_ffff, BOUND_ODD, 16'h0000, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k3, 0, 0, BOUND_EXACT, 0, 32'sh7fff_ffff,
                             32'sh8000_0000));
    req_backlog.push_back(mk(FUNC_STORE, k3, 10, 1, BOUND_LOWER, 16'h5555, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, k3, 50, 0, BOUND_EXACT, 0, 0, 0));
    req_backlog.push_back(mk(FUNC_STORE, ones, 127, 32'sh7fff_ffff, BOUND_EXACT, 16'hffff,
                             0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, ones, 127, 0, BOUND_EXACT, 0, 0, 32'sh7fff_ffff));
    req_backlog.push_back(mk(FUNC_STORE, '0, 0, -1, BOUND_LOWER, 16'h8001, 0, 0));
    req_backlog.push_back(mk(FUNC_PROBE, '0, 0, 0, BOUND_EXACT, 0, 0, 32'sh8000_0000));
    drain();

    queue_random_phase(RANDOM_WORDS);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 19;
    queue_random_phase(RANDOM_WORDS);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 400;
    queue_random_phase(RANDOM_WORDS);
    drain();

    repeat (16) @(posedge clk);
    $display("covered %0d probes (%0d key hits, %0d usable scores), %0d stores (%0d overwrites)",
             n_probes, n_hits, n_usable, n_stores, n_overwrites);
    $display("%0d mismatches under sender-heavy, receiver-heavy and gap-free traffic",
             mismatches);
    if (mismatches == 0) begin
      $display("depth_preferred_transposition_table test passed");
    end else begin
      $display("depth_preferred_transposition_table test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dptt_pkg.sv
rtl/dptt_slot.sv
rtl/dptt_table.sv
rtl/depth_preferred_transposition_table.sv
verif/depth_preferred_transposition_table_test.sv
